// ----- rtl/lne_pkg.sv -----
// Package for the line editor with echo: character codes, capacity limits
// and the command record passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package lne_pkg;

  // Depth of the line store seen by the host; capacity is clamped to this
  localparam int LINE_DEPTH = 256;
  localparam int CAP_TOP    = (LINE_DEPTH > 256) ? 256 : LINE_DEPTH;

  localparam logic [8:0] CAP_MAX   = 9'(CAP_TOP);
  localparam logic [8:0] CAP_MIN   = 9'd2;
  localparam logic [8:0] CAP_RESET = 9'd256;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_TERM  = 8'h00;

  // Command queue between front and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_ERASE,     // echo BS SP BS
    CMD_ENTER,     // terminator at idx, echo CR LF
    CMD_CHAR,      // store and echo ch at idx
    CMD_CHAR_END   // store and echo ch at idx, terminator at len, CR LF
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic [7:0] idx;
    logic [7:0] len;
  } cmd_t;

endpackage

// ----- rtl/lne_front.sv -----
// Front end of the line editor: holds the capacity register and the
// character count, classifies each received byte and queues a command.
// Depends on lne_pkg.
`timescale 1ns / 1ps

module lne_front import lne_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [8:0] cap_r;
  logic [7:0] count_r;
  logic [7:0] count_nxt;
  logic [8:0] cap_eff;
  logic [7:0] limit;
  logic [7:0] count_inc;
  logic       accept;
  logic       has_cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && has_cmd;

  // Clamp the capacity and derive the highest character count
  always_comb begin
    if (cap_r > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else if (cap_r < CAP_MIN) begin
      cap_eff = CAP_MIN;
    end else begin
      cap_eff = cap_r;
    end
    limit     = 8'(cap_eff - 9'd1);
    count_inc = count_r + 8'd1;
  end

  // Classify the byte and build its command
  always_comb begin
    count_nxt = count_r;
    has_cmd   = 1'b0;
    q_cmd     = '{kind: CMD_CHAR, ch: in_byte, idx: count_r, len: count_r};
    case (in_byte) inside
      CH_BS, CH_DEL: begin
        if (count_r != 8'd0) begin
          has_cmd    = 1'b1;
          count_nxt  = count_r - 8'd1;
          q_cmd.kind = CMD_ERASE;
          q_cmd.len  = count_r - 8'd1;
        end
      end
      CH_CR, CH_LF: begin
        has_cmd    = 1'b1;
        count_nxt  = 8'd0;
        q_cmd.kind = CMD_ENTER;
        q_cmd.idx  = (count_r < limit) ? count_r : limit;
        q_cmd.len  = (count_r < limit) ? count_r : limit;
      end
      [CH_SP:CH_TILDE]: begin
        has_cmd = 1'b1;
        if (count_r >= limit) begin
          // line already full: drop the byte and close the line
          count_nxt  = 8'd0;
          q_cmd.kind = CMD_ENTER;
          q_cmd.idx  = limit;
          q_cmd.len  = limit;
        end else if (count_inc >= limit) begin
          count_nxt  = 8'd0;
          q_cmd.kind = CMD_CHAR_END;
          q_cmd.len  = limit;
        end else begin
          count_nxt  = count_inc;
          q_cmd.kind = CMD_CHAR;
          q_cmd.len  = count_inc;
        end
      end
      default: begin
        // drop NUL and unprintable bytes
      end
    endcase
  end

  // Hold capacity and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      count_r <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

endmodule

// ----- rtl/lne_queue.sv -----
// Short command queue between the front and back end of the line editor.
// Show-ahead read of the head entry. Depends on lne_pkg.
`timescale 1ns / 1ps

module lne_queue import lne_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;

  assign full     = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (fill_r == '0);
  assign head_cmd = entries_r[rd_ptr_r];

  // Write entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/lne_back.sv -----
// Back end of the line editor: expands each queued command into one to
// three echo transactions held in an output register. Depends on lne_pkg.
`timescale 1ns / 1ps

module lne_back import lne_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_data,
  output logic        out_last,
  output logic [1:0]  out_flags
);

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_last_r;
  logic [1:0]  out_flags_r;
  logic [1:0]  beat_r;

  logic        load;
  logic [7:0]  echo;
  logic        sv;
  logic [7:0]  sidx;
  logic [7:0]  sbyte;
  logic        done;
  logic        last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;
  assign out_flags = out_flags_r;

  assign load  = !q_empty && (!out_valid_r || out_ready);
  assign q_pop = load && last;

  // Build the current beat of the head command
  always_comb begin
    echo  = CH_LF;
    sv    = 1'b0;
    sidx  = 8'd0;
    sbyte = 8'd0;
    done  = 1'b0;
    last  = 1'b0;
    case (q_head.kind)
      CMD_ERASE: begin
        echo = (beat_r == 2'd1) ? CH_SP : CH_BS;
        last = (beat_r == 2'd2);
      end
      CMD_ENTER: begin
        done = 1'b1;
        if (beat_r == 2'd0) begin
          echo = CH_CR;
          sv   = 1'b1;
          sidx = q_head.idx;
        end else begin
          last = 1'b1;
        end
      end
      CMD_CHAR: begin
        echo  = q_head.ch;
        sv    = 1'b1;
        sidx  = q_head.idx;
        sbyte = q_head.ch;
        last  = 1'b1;
      end
      CMD_CHAR_END: begin
        done = 1'b1;
        if (beat_r == 2'd0) begin
          echo  = q_head.ch;
          sv    = 1'b1;
          sidx  = q_head.idx;
          sbyte = q_head.ch;
        end else if (beat_r == 2'd1) begin
          echo = CH_CR;
          sv   = 1'b1;
          sidx = q_head.len;
        end else begin
          last = 1'b1;
        end
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  // Load the output register and step through the beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= 2'd0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      beat_r      <= last ? 2'd0 : beat_r + 2'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r  <= {q_head.len, sbyte, sidx, echo};
      out_last_r  <= last;
      out_flags_r <= {done, sv};
    end
  end

endmodule

// ----- rtl/line_editor_with_echo_unit.sv -----
// Top level of the line editor with echo: front end, command queue and
// back end. Depends on lne_pkg, lne_front, lne_queue and lne_back.
`timescale 1ns / 1ps
//
// Usage
//   in_*  : one received byte per transaction (in_tdata = rx_byte).
//   out_* : echo transactions. out_tlast marks the final echo caused by one
//           received byte; out_tuser carries the store write and line-done
//           flags; out_tdata carries echo byte, store index and byte, and
//           the line length.
//   cfg_* : write of line_capacity (clamped to 2..256), only while idle.
// Path: an accepted byte's command is written into the command queue, and
//   its first echo is then loaded from the queue head into the output register.
// Throughput: a byte is accepted every cycle while the four-entry command
//   queue has room. The back end sends one echo per cycle while out_tready
//   is high, so a byte takes one echo (printable), two (enter, or a printable
//   byte dropped on an already full line) or three (erase, a printable byte
//   that fills the line) of the output channel; NUL, unprintable bytes and
//   erase on an empty line take none.
// Reset: the count returns to 0, capacity to 256, the queue and output
//   register empty. A stalled receiver holds the output register; the
//   queue then fills and in_tready drops.

module line_editor_with_echo_unit import lne_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,   // line_capacity
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [7:0] echo_byte, [15:8] store_index,
                                     // [23:16] store_byte, [31:24] line_length
  output logic        out_tlast,     // last_of_run
  output logic [1:0]  out_tuser      // [0] store_valid, [1] line_done
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_in_cmd;
  cmd_t q_head;

  // Accept and classify
  lne_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_byte     (in_tdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_in_cmd)
  );

  // Decouple front and back
  lne_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Expand commands into echo transactions
  lne_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_flags (out_tuser)
  );

`ifndef SYNTHESIS
  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // Without a store write the store fields read zero
  a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[23:8] == 16'd0))
    else $error("store fields set without store write");

  // A terminator write sits at the reported line length
  a_term_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] && out_tuser[1] && out_tdata[23:16] == CH_TERM)
      |-> (out_tdata[15:8] == out_tdata[31:24]))
    else $error("terminator index differs from line length");

  // Pop only a present command
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command queue underflow");
`endif

endmodule
